FILE: sv/psl_pkg.sv
// shared types and constants for the prime sieve lister
package psl_pkg;

    localparam int unsigned LIMIT_MAX_DEF = 65535;

    // command field codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_PCHK,
        S_PWAIT,
        S_MARK,
        S_SCAN_INIT,
        S_SCAN_NEXT
    } t_state;

    typedef struct packed {
        logic load_lim;
        logic clear_wr;
        logic p_init;
        logic p_rd;
        logic p_next;
        logic q_init;
        logic mark;
        logic scan_init;
        logic from_cur;
        logic scan;
        logic cur_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_end;
        logic sq_over;
        logic prime_bit;
        logic q_over;
        logic scan_hit;
        logic scan_miss;
        logic cur_valid;
    } t_dp_stat;

endpackage

FILE: sv/psl_ram.sv
// generic simple dual port ram with registered read
module psl_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/psl_ctrl.sv
// sequencer for clear, sieve and scan phases
module psl_ctrl
    import psl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_command == CMD_START) begin
                        n_state = S_CLEAR;
                    end else if (i_stat.cur_valid) begin
                        n_state = S_SCAN_NEXT;
                    end
                end
            end
            S_CLEAR: begin
                if (i_stat.clear_end) begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                n_state = i_stat.sq_over ? S_SCAN_INIT : S_PWAIT;
            end
            S_PWAIT: begin
                n_state = i_stat.prime_bit ? S_MARK : S_PCHK;
            end
            S_MARK: begin
                if (i_stat.q_over) begin
                    n_state = S_PCHK;
                end
            end
            S_SCAN_INIT, S_SCAN_NEXT: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_command == CMD_START) begin
                        o_cmd.load_lim = 1'b1;
                    end else if (i_stat.cur_valid) begin
                        o_cmd.scan_init = 1'b1;
                        o_cmd.from_cur  = 1'b1;
                    end else begin
                        // nothing left: answer not found at once
                        o_cmd.out_load = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.p_init   = i_stat.clear_end;
            end
            S_PCHK: begin
                if (i_stat.sq_over) begin
                    o_cmd.scan_init = 1'b1;
                end else begin
                    o_cmd.p_rd = 1'b1;
                end
            end
            S_PWAIT: begin
                if (i_stat.prime_bit) begin
                    o_cmd.q_init = 1'b1;
                end else begin
                    o_cmd.p_next = 1'b1;
                end
            end
            S_MARK: begin
                if (i_stat.q_over) begin
                    o_cmd.p_next = 1'b1;
                end else begin
                    o_cmd.mark = 1'b1;
                end
            end
            S_SCAN_INIT: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    o_cmd.cur_load = 1'b1;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SCAN_NEXT: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    o_cmd.cur_load = 1'b1;
                    o_cmd.out_load = 1'b1;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sv/psl_dp.sv
// composite map, sieve counters, scan cursor and result registers
module psl_dp
    import psl_pkg::*;
#(
    parameter int unsigned LIMIT_MAX = LIMIT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_limit,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_strobe,
    output logic        o_found,
    output logic [15:0] o_prime,
    output logic        o_last
);

    localparam int unsigned DEPTH = LIMIT_MAX + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = AW + 1;
    localparam logic [31:0] LIM_MAX32 = LIMIT_MAX;

    logic [CW-1:0] r_lim;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_rd_addr;
    logic          r_rd_valid;
    logic [CW-1:0] r_p;
    logic [CW-1:0] r_sq;
    logic [CW-1:0] r_q;
    logic [AW-1:0] r_cur;
    logic          r_cur_valid;
    logic          r_strobe;
    logic          r_found;
    logic [15:0]   r_prime;
    logic          r_last;

    logic [31:0]   lim32;
    logic [31:0]   sat32;
    logic [CW-1:0] scan_from;
    logic          issue;
    logic          ram_we;
    logic [CW-1:0] waddr;
    logic          wdata;
    logic [CW-1:0] raddr;
    logic          rdata;
    logic [31:0]   cur32;

    assign lim32 = {16'd0, i_limit};
    assign sat32 = (lim32 > LIM_MAX32) ? LIM_MAX32 : lim32;
    assign cur32 = 32'(r_cur);

    assign scan_from = i_cmd.from_cur ? ({1'b0, r_cur} + CW'(1)) : CW'(2);
    assign issue     = i_cmd.scan && (r_addr <= r_lim);

    assign ram_we = i_cmd.clear_wr | i_cmd.mark;
    assign waddr  = i_cmd.mark ? r_q : r_addr;
    // 0 and 1 are marked composite during the clear sweep
    assign wdata  = i_cmd.mark | (r_addr < CW'(2));
    assign raddr  = i_cmd.p_rd ? r_p : r_addr;

    psl_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim       <= '0;
            r_rd_valid  <= 1'b0;
            r_cur_valid <= 1'b0;
            r_strobe    <= 1'b0;
            r_found     <= 1'b0;
            r_prime     <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cmd.load_lim) begin
                r_lim <= sat32[CW-1:0];
            end

            if (i_cmd.scan_init) begin
                r_rd_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_valid <= issue;
            end

            if (i_cmd.load_lim) begin
                r_cur_valid <= 1'b0;
            end else if (i_cmd.cur_load) begin
                r_cur_valid <= o_stat.scan_hit;
            end

            r_strobe <= i_cmd.out_load;
            if (i_cmd.out_load) begin
                r_found <= r_cur_valid;
                r_prime <= r_cur_valid ? cur32[15:0] : 16'd0;
                // last when no further prime turned up behind the current one
                r_last  <= r_cur_valid & ~o_stat.scan_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lim) begin
            r_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_addr <= r_addr + CW'(1);
        end else if (i_cmd.scan_init) begin
            r_addr <= scan_from;
        end else if (issue) begin
            r_addr <= r_addr + CW'(1);
        end

        if (issue) begin
            r_rd_addr <= r_addr;
        end

        // square kept incrementally: (p+1)^2 = p^2 + 2p + 1
        if (i_cmd.p_init) begin
            r_p  <= CW'(2);
            r_sq <= CW'(4);
        end else if (i_cmd.p_next) begin
            r_p  <= r_p + CW'(1);
            r_sq <= r_sq + {r_p[CW-2:0], 1'b1};
        end

        if (i_cmd.q_init) begin
            r_q <= r_sq;
        end else if (i_cmd.mark) begin
            r_q <= r_q + r_p;
        end

        if (i_cmd.cur_load) begin
            r_cur <= r_rd_addr[AW-1:0];
        end
    end

    assign o_stat.clear_end = (r_addr == r_lim);
    assign o_stat.sq_over   = (r_sq > r_lim);
    assign o_stat.prime_bit = ~rdata;
    assign o_stat.q_over    = (r_q > r_lim);
    assign o_stat.scan_hit  = r_rd_valid & ~rdata;
    assign o_stat.scan_miss = ~r_rd_valid & (r_addr > r_lim);
    assign o_stat.cur_valid = r_cur_valid;

    assign o_strobe = r_strobe;
    assign o_found  = r_found;
    assign o_prime  = r_prime;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (waddr <= r_lim))
        else $error("map write above limit");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (({1'b0, r_cur} <= r_lim) && (r_cur >= AW'(2))))
        else $error("pending prime outside sieve range");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_found) |-> ((r_prime == 16'd0) && !r_last))
        else $error("not found result carries data");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.out_load))
        else $error("result strobe without load");
`endif

endmodule

FILE: sv/prime_sieve_lister.sv
// top level of the sieve of eratosthenes prime lister
// Usage: an item (i_command, i_limit) is taken at a rising edge where start is
// high and busy is low. A start item (i_command = 0) saturates i_limit to
// LIMIT_MAX, clears a one-bit composite map over 0..limit, sieves it and then
// looks up the first prime; it gives no result. A next item (i_command = 1)
// gives one result: o_found, o_prime and o_last are valid in the single cycle
// o_strobe is high. o_last flags the largest prime up to the limit; after it,
// and before any start or with a limit below 2, results come back not found.
// A next item with nothing left answers not found without a scan. Otherwise
// it scans the map from the pending prime to the one after it, or to the
// limit for the last one, one map bit per cycle through the registered read
// port. A start item clears the map over 0..limit, checks each candidate p
// with p*p <= limit, marks the multiples of each prime p from p*p up to the
// limit, ends the sieve with a final check and then scans to the first prime;
// clearing and marking share the single write port of the map.
// Reset returns the block to idle with no sieve built. Results are never held
// off: the receiver must take each one in its strobe cycle.
module prime_sieve_lister
    import psl_pkg::*;
#(
    parameter int unsigned LIMIT_MAX = LIMIT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_limit,
    output logic        o_strobe,
    output logic        o_found,
    output logic [15:0] o_prime,
    output logic        o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    psl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    psl_dp #(
        .LIMIT_MAX (LIMIT_MAX)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (i_limit),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_found  (o_found),
        .o_prime  (o_prime),
        .o_last   (o_last)
    );

endmodule
